### rtl/hvd_pkg.sv
// Package with the opcodes and the result type of the Viterbi decoder.
package hvd_pkg;

  localparam int OP_W = 3;
  localparam int STATE_FIELD_W = 3;
  localparam int SYMBOL_FIELD_W = 4;
  localparam int COST_FIELD_W = 16;
  localparam int STEP_FIELD_W = 6;

  localparam logic [OP_W-1:0] OP_LOAD_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TRANS = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_EMIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_OBSERVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_FINISH     = 3'd4;

  typedef struct packed {
    logic [STEP_FIELD_W-1:0]  step_index;
    logic [STATE_FIELD_W-1:0] best_state;
    logic                     found;
    logic                     overflowed;
    logic                     last;
  } result_t;

endpackage

### rtl/hvd_in_if.sv
// Input channel interface of the Viterbi decoder.
interface hvd_in_if;
  logic                                valid;
  logic                                ready;
  logic [hvd_pkg::OP_W-1:0]            op;
  logic [hvd_pkg::STATE_FIELD_W-1:0]   from_state;
  logic [hvd_pkg::STATE_FIELD_W-1:0]   to_state;
  logic [hvd_pkg::SYMBOL_FIELD_W-1:0]  symbol;
  logic [hvd_pkg::COST_FIELD_W-1:0]    cost;
  modport source (output valid, op, from_state, to_state, symbol, cost, input ready);
  modport sink (input valid, op, from_state, to_state, symbol, cost, output ready);
endinterface

### rtl/hvd_out_if.sv
// Result channel interface of the Viterbi decoder.
interface hvd_out_if;
  logic                                valid;
  logic                                ready;
  logic [hvd_pkg::STEP_FIELD_W-1:0]    step_index;
  logic [hvd_pkg::STATE_FIELD_W-1:0]   best_state;
  logic                                found;
  logic                                overflowed;
  logic                                last;
  modport source (output valid, step_index, best_state, found, overflowed, last, input ready);
  modport sink (input valid, step_index, best_state, found, overflowed, last, output ready);
endinterface

### rtl/hmm_viterbi_decoder.sv
// Viterbi decoder for a hidden Markov model: table loads, ACS steps, traceback.
//
// Load items are taken while idle and do not stall the input. An observe item
// keeps the input stalled after it is accepted, unless the sequence is already
// full. The transition memory has one read port, so each destination state
// first reads its emission, then scans its predecessors one per cycle, and a
// copy state takes over the new metrics after the last destination. The first
// observe of a sequence skips the predecessor scan and adds the initial costs.
// A finish scans the path metrics to pick the final state. Traceback then
// alternates backpointer reads with writes into a sequence buffer. After that
// the results leave in step order, held while the sink holds them off. After
// reset a clearing pass over all NUM_SYMBOLS*NUM_STATES entries sets the
// emission memory to zero probability; no item is accepted meanwhile.
module hmm_viterbi_decoder #(
  parameter int NUM_STATES  = 8,
  parameter int NUM_SYMBOLS = 16,
  parameter int MAX_STEPS   = 64,
  parameter int COST_WIDTH  = 16
) (
  input logic clk,
  input logic rst_n,
  hvd_in_if.sink   in_ch,
  hvd_out_if.source out_ch
);

  localparam int SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int YW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int TW  = $clog2(NUM_STATES * NUM_STATES);
  localparam int EW  = $clog2(NUM_SYMBOLS * NUM_STATES);
  localparam int PW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW  = $clog2(MAX_STEPS + 1);
  localparam int SCW = $clog2(NUM_STATES + 1);
  localparam int FW  = hvd_pkg::STATE_FIELD_W;
  localparam int YFW = hvd_pkg::SYMBOL_FIELD_W;
  localparam logic [COST_WIDTH-1:0] ZP = '1;

  // Sequencer codes.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_OBS   = 4'd2;
  localparam logic [3:0] ST_OBSW  = 4'd3;
  localparam logic [3:0] ST_COPY  = 4'd4;
  localparam logic [3:0] ST_FMIN  = 4'd5;
  localparam logic [3:0] ST_TBRD  = 4'd6;
  localparam logic [3:0] ST_TBWT  = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  // Saturating cost sum; zero probability absorbs.
  function automatic logic [COST_WIDTH-1:0] sat_add(input logic [COST_WIDTH-1:0] a,
                                                    input logic [COST_WIDTH-1:0] b);
    logic [COST_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == ZP || b == ZP || s >= {1'b0, ZP}) return ZP;
    return s[COST_WIDTH-1:0];
  endfunction

  // Small tables in flip-flops.
  logic [COST_WIDTH-1:0] init_r  [NUM_STATES];
  logic [COST_WIDTH-1:0] pm_r    [NUM_STATES];
  logic [COST_WIDTH-1:0] nxt_pm_r[NUM_STATES];
  logic [NUM_STATES*NUM_STATES-1:0] tvalid_r;

  // Memories.
  logic [COST_WIDTH-1:0] trans_mem [NUM_STATES*NUM_STATES];
  logic [COST_WIDTH-1:0] emit_mem  [NUM_SYMBOLS*NUM_STATES];
  logic [SW-1:0]         bp_mem    [MAX_STEPS*NUM_STATES];
  logic [SW-1:0]         seq_mem   [MAX_STEPS];

  logic [3:0]   state_r;
  logic [EW:0]  clr_r;
  logic [CW-1:0] steps_r;
  logic          ovf_r;
  logic [SW-1:0] j_r, k_r;
  logic [SCW-1:0] kc_r;
  logic          rd_ok_r;
  logic [SW-1:0] rd_k_r;
  logic          sym_ok_r;
  logic [YW-1:0] sym_r;
  logic [COST_WIDTH-1:0] e_r, best_r;
  logic [SW-1:0] arg_r;
  logic [CW-1:0] ti_r;
  logic [SW-1:0] cur_r;
  logic [COST_WIDTH-1:0] t_rd_r, e_rd_r;
  logic [SW-1:0] bp_rd_r;
  logic [SW-1:0] seq_rd_r;
  logic          tv_rd_r;
  logic          out_valid_r;
  hvd_pkg::result_t res_r;
  logic [CW-1:0] oi_r;
  logic          nopath_r;

  logic acc;
  logic st_ok, ts_ok, sy_ok;
  logic [COST_WIDTH-1:0] cost_in;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [EW-1:0] e_addr;
  logic          e_we;
  logic [COST_WIDTH-1:0] e_wdata;
  logic [COST_WIDTH-1:0] cand;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc = in_ch.valid && in_ch.ready;

  assign st_ok = {{(32-FW){1'b0}}, in_ch.from_state} < NUM_STATES;
  assign ts_ok = {{(32-FW){1'b0}}, in_ch.to_state} < NUM_STATES;
  assign sy_ok = {{(32-YFW){1'b0}}, in_ch.symbol} < NUM_SYMBOLS;
  assign cost_in = COST_WIDTH'(in_ch.cost & hvd_pkg::COST_FIELD_W'(ZP));

  assign t_waddr = TW'(in_ch.from_state) * TW'(NUM_STATES) + TW'(in_ch.to_state);
  assign t_raddr = TW'(k_r) * TW'(NUM_STATES) + TW'(j_r);

  // Emission port: clear sweep, load, or read for the current destination.
  always_comb begin
    e_we = 1'b0;
    e_wdata = cost_in;
    e_addr = EW'(sym_r) * EW'(NUM_STATES) + EW'(j_r);
    if (state_r == ST_CLEAR) begin
      e_we = 1'b1;
      e_wdata = ZP;
      e_addr = clr_r[EW-1:0];
    end else if (acc && in_ch.op == hvd_pkg::OP_LOAD_EMIT && st_ok && sy_ok) begin
      e_we = 1'b1;
      e_addr = EW'(in_ch.symbol) * EW'(NUM_STATES) + EW'(in_ch.from_state);
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) emit_mem[e_addr] <= e_wdata;
    e_rd_r <= emit_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.op == hvd_pkg::OP_LOAD_TRANS && st_ok && ts_ok)
      trans_mem[t_waddr] <= cost_in;
    t_rd_r <= trans_mem[t_raddr];
    tv_rd_r <= tvalid_r[t_raddr];
  end

  // Candidate for the predecessor read last cycle.
  always_comb begin
    cand = sat_add(sat_add(pm_r[rd_k_r], tv_rd_r ? t_rd_r : ZP), e_r);
  end

  // Backpointer and sequence memories.
  logic          bp_we;
  logic [PW-1:0] bp_step;
  logic [SW-1:0] bp_j;
  logic [SW-1:0] bp_wd;
  logic [PW-1:0] tb_step;
  assign bp_step = PW'(steps_r);
  assign tb_step = PW'(ti_r);
  always_ff @(posedge clk) begin
    if (bp_we) bp_mem[{bp_step, bp_j}] <= bp_wd;
    bp_rd_r <= bp_mem[{tb_step, cur_r}];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TBWT) seq_mem[PW'(ti_r)] <= cur_r;
    seq_rd_r <= seq_mem[PW'(oi_r)];
  end

  // Main control.
  always_comb begin
    bp_we = 1'b0;
    bp_j  = j_r;
    bp_wd = arg_r;
    if (state_r == ST_OBSW) begin
      bp_we = 1'b1;
      if (kc_r != '0 && steps_r != '0 && cand < best_r) bp_wd = rd_k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      steps_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
      tvalid_r <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        init_r[i] <= ZP;
        pm_r[i] <= ZP;
      end
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (EW+1)'(NUM_SYMBOLS*NUM_STATES-1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) begin
            case (in_ch.op)
              hvd_pkg::OP_LOAD_INIT:
                if (st_ok) init_r[SW'(in_ch.from_state)] <= cost_in;
              hvd_pkg::OP_LOAD_TRANS:
                if (st_ok && ts_ok) tvalid_r[t_waddr] <= 1'b1;
              hvd_pkg::OP_OBSERVE: begin
                if (steps_r == CW'(MAX_STEPS)) ovf_r <= 1'b1;
                else begin
                  sym_r <= YW'(in_ch.symbol);
                  sym_ok_r <= sy_ok;
                  j_r <= '0;
                  k_r <= '0;
                  kc_r <= '0;
                  state_r <= ST_OBS;
                end
              end
              hvd_pkg::OP_FINISH: begin
                k_r <= '0;
                kc_r <= '0;
                best_r <= ZP;
                arg_r <= '0;
                state_r <= ST_FMIN;
              end
              default: ;
            endcase
          end
        end
        // ST_OBS reads the emission of a destination; ST_OBSW then scans its predecessors.
        ST_OBS: begin
          rd_ok_r <= 1'b1;
          rd_k_r <= k_r;
          state_r <= ST_OBSW;
          kc_r <= '0;
          best_r <= ZP;
          arg_r <= '0;
          k_r <= '0;
        end
        ST_OBSW: begin
          if (kc_r == '0) begin
            e_r <= sym_ok_r ? e_rd_r : ZP;
            if (steps_r == '0) begin
              nxt_pm_r[j_r] <= sat_add(init_r[j_r], sym_ok_r ? e_rd_r : ZP);
              if (j_r == SW'(NUM_STATES-1)) state_r <= ST_COPY;
              else begin
                j_r <= j_r + 1'b1;
                state_r <= ST_OBS;
              end
            end else begin
              kc_r <= kc_r + 1'b1;
              rd_k_r <= k_r;
              k_r <= k_r + 1'b1;
            end
          end else begin
            if (cand < best_r) begin
              best_r <= cand;
              arg_r <= rd_k_r;
            end
            rd_k_r <= k_r;
            if (kc_r == SCW'(NUM_STATES)) begin
              nxt_pm_r[j_r] <= (cand < best_r) ? cand : best_r;
              kc_r <= '0;
              k_r <= '0;
              if (j_r == SW'(NUM_STATES-1)) state_r <= ST_COPY;
              else begin
                j_r <= j_r + 1'b1;
                state_r <= ST_OBS;
              end
            end else begin
              k_r <= k_r + 1'b1;
              kc_r <= kc_r + 1'b1;
            end
          end
        end
        ST_COPY: begin
          for (int i = 0; i < NUM_STATES; i++) pm_r[i] <= nxt_pm_r[i];
          steps_r <= steps_r + 1'b1;
          state_r <= ST_IDLE;
        end
        ST_FMIN: begin
          if (pm_r[k_r] < best_r) begin
            best_r <= pm_r[k_r];
            arg_r <= k_r;
          end
          k_r <= k_r + 1'b1;
          if (k_r == SW'(NUM_STATES-1)) begin
            nopath_r <= (steps_r == '0) || !(pm_r[k_r] < best_r) && best_r == ZP;
            cur_r <= (pm_r[k_r] < best_r) ? k_r : arg_r;
            ti_r <= steps_r - 1'b1;
            oi_r <= '0;
            rd_ok_r <= 1'b0;
            state_r <= ST_TBWT;
          end
        end
        ST_TBWT: begin
          if (nopath_r || ti_r == '0) state_r <= ST_EMIT;
          else state_r <= ST_TBRD;
        end
        ST_TBRD: begin
          cur_r <= bp_rd_r;
          ti_r <= ti_r - 1'b1;
          state_r <= ST_TBWT;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            if (rd_ok_r) begin
              out_valid_r <= 1'b1;
              res_r.step_index <= hvd_pkg::STEP_FIELD_W'(oi_r);
              res_r.best_state <= nopath_r ? '0 : FW'(seq_rd_r);
              res_r.found <= !nopath_r;
              res_r.overflowed <= ovf_r;
              res_r.last <= nopath_r || (oi_r + 1'b1 == steps_r);
              if (nopath_r || oi_r + 1'b1 == steps_r) begin
                steps_r <= '0;
                ovf_r <= 1'b0;
                for (int i = 0; i < NUM_STATES; i++) pm_r[i] <= ZP;
                state_r <= ST_IDLE;
              end
              oi_r <= oi_r + 1'b1;
              rd_ok_r <= 1'b0;
            end else begin
              rd_ok_r <= 1'b1;
              if (out_valid_r) out_valid_r <= 1'b0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (out_valid_r && out_ch.ready && state_r != ST_EMIT) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.step_index = res_r.step_index;
  assign out_ch.best_state = res_r.best_state;
  assign out_ch.found      = res_r.found;
  assign out_ch.overflowed = res_r.overflowed;
  assign out_ch.last       = res_r.last;

endmodule

### tb/hmm_viterbi_decoder_tb.sv
// Self-checking testbench of the HMM Viterbi decoder: table loads, decoding runs and tracebacks.
`timescale 1ns / 1ps

module hmm_viterbi_decoder_tb;

  localparam int N_ST = 8;
  localparam int N_SYM = 16;
  localparam int MAX_OBS = 64;
  localparam int OPW = hvd_pkg::OP_W;
  localparam logic [hvd_pkg::COST_FIELD_W-1:0] NO_PATH = '1;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 1500;

  // Op codes that the block ignores.
  localparam logic [OPW-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OPW-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OPW-1:0] OP_SPARE_HI  = 3'd7;

  typedef struct {
    logic [hvd_pkg::OP_W-1:0]           op;
    logic [hvd_pkg::STATE_FIELD_W-1:0]  from_state;
    logic [hvd_pkg::STATE_FIELD_W-1:0]  to_state;
    logic [hvd_pkg::SYMBOL_FIELD_W-1:0] symbol;
    logic [hvd_pkg::COST_FIELD_W-1:0]   cost;
  } dec_item_t;

  logic clk;
  logic rst_n;

  hvd_in_if  in_ch ();
  hvd_out_if out_ch ();

  hmm_viterbi_decoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Model copy of the decoder state.
  logic [hvd_pkg::COST_FIELD_W-1:0]  init_tbl [N_ST];
  logic [hvd_pkg::COST_FIELD_W-1:0]  trans_tbl [N_ST][N_ST];
  logic [hvd_pkg::COST_FIELD_W-1:0]  emit_tbl [N_SYM][N_ST];
  logic [hvd_pkg::COST_FIELD_W-1:0]  metric [N_ST];
  logic [hvd_pkg::STATE_FIELD_W-1:0] survivor [MAX_OBS][N_ST];
  int                                obs_count;
  logic                              dropped;

  hvd_pkg::result_t decoded_q [$];
  int      errors = 0;
  int      tx_idle;
  int      rx_idle;
  int      hold_reqs;
  int      hold_seen = 0;
  int      hold_cnt = 0;
  int      quiet_cycles = 0;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [hvd_pkg::COST_FIELD_W-1:0] cost_add(
      logic [hvd_pkg::COST_FIELD_W-1:0] a, logic [hvd_pkg::COST_FIELD_W-1:0] b);
    logic [hvd_pkg::COST_FIELD_W:0] s;
    if (a == NO_PATH || b == NO_PATH) begin
      return NO_PATH;
    end
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, NO_PATH}) ? NO_PATH : s[hvd_pkg::COST_FIELD_W-1:0];
  endfunction

  task automatic clear_model_sequence();
    for (int s = 0; s < N_ST; s++) begin
      metric[s] = NO_PATH;
    end
    obs_count = 0;
    dropped = 1'b0;
  endtask

  // One add-compare-select step over all destination states.
  task automatic acs_step(logic [hvd_pkg::SYMBOL_FIELD_W-1:0] sym);
    logic [hvd_pkg::COST_FIELD_W-1:0] nxt [N_ST];
    logic [hvd_pkg::COST_FIELD_W-1:0] best;
    logic [hvd_pkg::COST_FIELD_W-1:0] cand;
    logic [hvd_pkg::STATE_FIELD_W-1:0] arg;
    if (obs_count >= MAX_OBS) begin
      dropped = 1'b1;
      return;
    end
    for (int j = 0; j < N_ST; j++) begin
      if (obs_count == 0) begin
        nxt[j] = cost_add(init_tbl[j], emit_tbl[sym][j]);
        survivor[0][j] = '0;
      end else begin
        best = NO_PATH;
        arg = '0;
        for (int k = 0; k < N_ST; k++) begin
          cand = cost_add(cost_add(metric[k], trans_tbl[k][j]), emit_tbl[sym][j]);
          if (cand < best) begin
            best = cand;
            arg = k[hvd_pkg::STATE_FIELD_W-1:0];
          end
        end
        nxt[j] = best;
        survivor[obs_count][j] = arg;
      end
    end
    metric = nxt;
    obs_count++;
  endtask

  // Pick the best final state, trace back and queue the decoded sequence.
  task automatic traceback_predict();
    logic [hvd_pkg::COST_FIELD_W-1:0]  best;
    logic [hvd_pkg::STATE_FIELD_W-1:0] arg;
    logic [hvd_pkg::STATE_FIELD_W-1:0] path [MAX_OBS];
    hvd_pkg::result_t r;
    best = NO_PATH;
    arg = '0;
    for (int s = 0; s < N_ST; s++) begin
      if (obs_count > 0 && metric[s] < best) begin
        best = metric[s];
        arg = s[hvd_pkg::STATE_FIELD_W-1:0];
      end
    end
    if (obs_count == 0 || best == NO_PATH) begin
      r = '{step_index: '0, best_state: '0, found: 1'b0, overflowed: dropped, last: 1'b1};
      decoded_q.insert(decoded_q.size(), r);
    end else begin
      path[obs_count-1] = arg;
      for (int i = obs_count - 1; i > 0; i--) begin
        path[i-1] = survivor[i][path[i]];
      end
      for (int i = 0; i < obs_count; i++) begin
        r.step_index = i[hvd_pkg::STEP_FIELD_W-1:0];
        r.best_state = path[i];
        r.found = 1'b1;
        r.overflowed = dropped;
        r.last = (i + 1 == obs_count);
        decoded_q.insert(decoded_q.size(), r);
      end
    end
    clear_model_sequence();
  endtask

  task automatic apply_to_model(dec_item_t it);
    case (it.op)
      hvd_pkg::OP_LOAD_INIT:  init_tbl[it.from_state] = it.cost;
      hvd_pkg::OP_LOAD_TRANS: trans_tbl[it.from_state][it.to_state] = it.cost;
      hvd_pkg::OP_LOAD_EMIT:  emit_tbl[it.symbol][it.from_state] = it.cost;
      hvd_pkg::OP_OBSERVE:    acs_step(it.symbol);
      hvd_pkg::OP_FINISH:     traceback_predict();
      default: ;
    endcase
  endtask

  // Offer one item, idling first at the current rate, and wait for acceptance.
  task automatic send_item(dec_item_t it);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.from_state <= it.from_state;
    in_ch.to_state <= it.to_state;
    in_ch.symbol <= it.symbol;
    in_ch.cost <= it.cost;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    apply_to_model(it);
  endtask

  task automatic send_fields(logic [OPW-1:0] op, int fs, int ts, int sym, int cost);
    dec_item_t it;
    it.op = op;
    it.from_state = fs[hvd_pkg::STATE_FIELD_W-1:0];
    it.to_state = ts[hvd_pkg::STATE_FIELD_W-1:0];
    it.symbol = sym[hvd_pkg::SYMBOL_FIELD_W-1:0];
    it.cost = cost[hvd_pkg::COST_FIELD_W-1:0];
    send_item(it);
  endtask

  // Costs biased toward small values, with zero probability and near-saturation mixed in.
  function automatic int pick_cost();
    case ($urandom_range(9))
      6: return int'(NO_PATH);
      7: return $urandom_range(65535);
      8: return $urandom_range(65534, 61440);
      9: return 0;
      default: return $urandom_range(2048);
    endcase
  endfunction

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Extremes of every field, each opcode and each special case in turn.
  task automatic test_directed();
    send_fields(hvd_pkg::OP_FINISH, 0, 0, 0, 0);
    send_fields(hvd_pkg::OP_OBSERVE, 0, 0, 15, 0);
    send_fields(hvd_pkg::OP_FINISH, 0, 0, 0, 0);
    for (int s = 0; s < N_ST; s++) begin
      send_fields(hvd_pkg::OP_LOAD_INIT, s, 0, 0, (s == 0) ? 'hFFFF : s * 256);
    end
    send_fields(hvd_pkg::OP_LOAD_TRANS, 7, 7, 0, 0);
    send_fields(hvd_pkg::OP_LOAD_TRANS, 0, 3, 0, 'hFFFE);
    send_fields(hvd_pkg::OP_LOAD_TRANS, 2, 5, 0, 'h0100);
    send_fields(hvd_pkg::OP_LOAD_EMIT, 7, 0, 15, 0);
    send_fields(hvd_pkg::OP_LOAD_EMIT, 3, 0, 15, 'h0100);
    send_fields(hvd_pkg::OP_LOAD_EMIT, 0, 0, 0, 'hFFFF);
    send_fields(hvd_pkg::OP_OBSERVE, 0, 0, 15, 0);
    send_fields(hvd_pkg::OP_OBSERVE, 7, 7, 15, 'hFFFF);
    send_fields(OP_SPARE_LO, 7, 7, 15, 'hFFFF);
    send_fields(OP_SPARE_MID, 0, 0, 0, 0);
    send_fields(OP_SPARE_HI, 5, 2, 10, 'h5555);
    send_fields(hvd_pkg::OP_FINISH, 7, 7, 15, 'hFFFF);
    wait_drain();
  endtask

  // Random runs: a few loads, observations, a finish; at times a lone spare op or finish.
  task automatic test_random(int n_items);
    int sent;
    int n_obs;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_fields(OPW'($urandom_range(int'(OP_SPARE_HI), int'(hvd_pkg::OP_FINISH))),
                    $urandom_range(7), $urandom_range(7),
                    $urandom_range(15), $urandom_range(65535));
        sent++;
        continue;
      end
      repeat ($urandom_range(6)) begin
        send_fields(OPW'($urandom_range(int'(hvd_pkg::OP_LOAD_EMIT),
                                        int'(hvd_pkg::OP_LOAD_INIT))),
                    $urandom_range(7), $urandom_range(7),
                    $urandom_range(15), pick_cost());
        sent++;
      end
      n_obs = ($urandom_range(39) == 0) ? $urandom_range(70, 60) : $urandom_range(1, 8);
      repeat (n_obs) begin
        send_fields(hvd_pkg::OP_OBSERVE, $urandom_range(7), $urandom_range(7),
                    $urandom_range(15), $urandom_range(65535));
        sent++;
      end
      send_fields(hvd_pkg::OP_FINISH, $urandom_range(7), $urandom_range(7),
                  $urandom_range(15), $urandom_range(65535));
      sent++;
    end
  endtask

  // Receiver holds off while the sender keeps going, so the block has to stall its input.
  task automatic test_backpressure();
    for (int s = 0; s < N_ST; s++) begin
      send_fields(hvd_pkg::OP_LOAD_INIT, s, 0, 0, 0);
      send_fields(hvd_pkg::OP_LOAD_EMIT, s, 0, 4, s * 16);
      send_fields(hvd_pkg::OP_LOAD_TRANS, s, (s + 1) % N_ST, 0, 'h0080);
    end
    hold_reqs++;
    repeat (12) send_fields(hvd_pkg::OP_OBSERVE, 0, 0, 4, 0);
    send_fields(hvd_pkg::OP_FINISH, 0, 0, 0, 0);
    repeat (3) send_fields(hvd_pkg::OP_OBSERVE, 0, 0, 4, 0);
    send_fields(hvd_pkg::OP_FINISH, 0, 0, 0, 0);
    send_fields(hvd_pkg::OP_FINISH, 0, 0, 0, 0);
    wait_drain();
  endtask

  // Result receiver with random stalls and an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_cnt <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin
    hvd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual idx=%0d state=%0d", $time,
                 out_ch.step_index, out_ch.best_state);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.step_index !== want.step_index) begin
          $display("%0t: step_index expected %0d actual %0d", $time, want.step_index,
                   out_ch.step_index);
          errors++;
        end
        if (out_ch.best_state !== want.best_state) begin
          $display("%0t: best_state expected %0d actual %0d", $time, want.best_state,
                   out_ch.best_state);
          errors++;
        end
        if (out_ch.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_ch.found);
          errors++;
        end
        if (out_ch.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b", $time, want.overflowed,
                   out_ch.overflowed);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    hold_reqs = 0;
    tx_idle = 0;
    rx_idle = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= '0;
    in_ch.from_state <= '0;
    in_ch.to_state <= '0;
    in_ch.symbol <= '0;
    in_ch.cost <= '0;
    for (int s = 0; s < N_ST; s++) begin
      init_tbl[s] = NO_PATH;
      for (int t = 0; t < N_ST; t++) begin
        trans_tbl[s][t] = NO_PATH;
      end
    end
    for (int y = 0; y < N_SYM; y++) begin
      for (int s = 0; s < N_ST; s++) begin
        emit_tbl[y][s] = NO_PATH;
      end
    end
    clear_model_sequence();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    tx_idle = 20;
    rx_idle = 79;
    test_random(100);
    test_backpressure();
    tx_idle = 79;
    rx_idle = 20;
    test_random(100);
    wait_drain();
    tx_idle = 0;
    rx_idle = 0;
    test_random(100);

    // Let the last results come out, then a quiet tail.
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hvd_pkg.sv
rtl/hvd_in_if.sv
rtl/hvd_out_if.sv
rtl/hmm_viterbi_decoder.sv
tb/hmm_viterbi_decoder_tb.sv
